### hdl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, register indexes and request/response types for the
// point-in-polygon crossing test unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int COORD_BITS   = 24;
    localparam int TOL_BITS     = 16;
    localparam int CFG_BITS     = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;
    localparam int CFG_IDX_BITS = 2;

    // coordinate differences, multiplier operands and products
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int MUL_BITS  = (DIFF_BITS > TOL_BITS + 1) ? DIFF_BITS : TOL_BITS + 1;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int NUM_BITS  = PROD_BITS + 1;
    localparam int CMP_BITS  = NUM_BITS + 1;
    // straddle thresholds: query_y +/- tolerance
    localparam int THR_BITS  = CFG_BITS + 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   valid;
        logic   ring_start;
        t_coord x1;
        t_coord y1;
        t_coord x2;
        t_coord y2;
    } t_edge_req;

    typedef struct packed {
        logic done;
        logic tog_right;
        logic tog_left;
        logic hit;
    } t_edge_rsp;

endpackage

### hdl/point_in_polygon_crossing_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test_unit
// Streams polygon vertices against a configured query point and reports
// inside / on-boundary at the end of each polygon.
// ----------------------------------------------------------------------------
// A vertex that forms a straddling edge goes through classify, three
//   passes through the shared multiplier, compare and update before the unit
//   is ready again; a ring start or non-straddling edge only classifies and updates.
// The last vertex of a polygon also loads the output register once it is free.
// A new vertex is taken only once the last one is done; there is a single shared multiplier.
// Reset (synchronous, active low) clears parities, boundary flag, previous
//   vertex, output valid; query point resets to 0 and tolerance to 1.
module point_in_polygon_crossing_test_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [pip_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [pip_pkg::CFG_BITS-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic                                 i_ring_start,
    input  logic                                 i_polygon_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_inside_res,
    output logic                                 o_on_boundary
);
    import pip_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EDGE = 3'b010,
        ST_EMIT = 3'b100
    } t_top_state;

    t_top_state r_state, n_state;

    t_coord              r_query_x, r_query_y;
    logic [TOL_BITS-1:0] r_tolerance;
    t_coord              r_prev_x, r_prev_y;
    logic                r_right_par, r_left_par, r_bnd_hit, r_last;
    logic                r_out_valid, r_out_inside, r_out_bnd;

    logic      in_accept, out_free, vertex_hit;
    t_edge_req edge_req;
    t_edge_rsp edge_rsp;

    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign vertex_hit = (i_vertex_x == r_query_x) && (i_vertex_y == r_query_y);

    always_comb begin
        edge_req.valid      = in_accept;
        edge_req.ring_start = i_ring_start;
        edge_req.x1         = r_prev_x;
        edge_req.y1         = r_prev_y;
        edge_req.x2         = i_vertex_x;
        edge_req.y2         = i_vertex_y;
    end

    pip_edge u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (edge_req),
        .i_query_x   (r_query_x),
        .i_query_y   (r_query_y),
        .i_tolerance (r_tolerance),
        .o_rsp       (edge_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_accept) begin
                n_state = ST_EDGE;
            end
            ST_EDGE: if (edge_rsp.done) begin
                n_state = r_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: if (out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_query_x    <= '0;
            r_query_y    <= '0;
            r_tolerance  <= TOL_BITS'(1);
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_right_par  <= 1'b0;
            r_left_par   <= 1'b0;
            r_bnd_hit    <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_inside <= 1'b0;
            r_out_bnd    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_QUERY_X:   r_query_x   <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_QUERY_Y:   r_query_y   <= i_cfg_wdata[COORD_BITS-1:0];
                    CFG_TOLERANCE: r_tolerance <= i_cfg_wdata[TOL_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_prev_x <= i_vertex_x;
                r_prev_y <= i_vertex_y;
                r_last   <= i_polygon_end;
                if (vertex_hit) r_bnd_hit <= 1'b1;
            end

            if (r_state == ST_EDGE && edge_rsp.done) begin
                r_right_par <= r_right_par ^ edge_rsp.tog_right;
                r_left_par  <= r_left_par ^ edge_rsp.tog_left;
                if (edge_rsp.hit) r_bnd_hit <= 1'b1;
            end

            // polygon done: publish and start the next one from a clean state
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_inside <= r_right_par | r_left_par | r_bnd_hit;
                r_out_bnd    <= r_bnd_hit;
                r_prev_x     <= '0;
                r_prev_y     <= '0;
                r_right_par  <= 1'b0;
                r_left_par   <= 1'b0;
                r_bnd_hit    <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_inside_res  = r_out_inside;
    assign o_on_boundary = r_out_bnd;

endmodule

### hdl/pip_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_mul
// Shared signed multiplier with a registered product; one result per cycle,
// available the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module pip_mul (
    input  logic                                i_clk,
    input  logic signed [pip_pkg::MUL_BITS-1:0]  i_a,
    input  logic signed [pip_pkg::MUL_BITS-1:0]  i_b,
    output logic signed [pip_pkg::PROD_BITS-1:0] o_prod
);
    import pip_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### hdl/pip_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge
// Edge sequencer: classifies one edge against the band around the query row;
// a straddling edge that is not a ring start then runs both cross products and
// the tolerance bound through the shared multiplier; offset compared by cross-multiplication.
// ----------------------------------------------------------------------------
module pip_edge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pip_pkg::t_edge_req                   i_req,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_query_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] i_query_y,
    input  logic [pip_pkg::TOL_BITS-1:0]          i_tolerance,
    output pip_pkg::t_edge_rsp                   o_rsp
);
    import pip_pkg::*;

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_CLS  = 6'b000010,
        E_MUL1 = 6'b000100,
        E_MUL2 = 6'b001000,
        E_MUL3 = 6'b010000,
        E_CMP  = 6'b100000
    } t_edge_state;

    t_edge_state r_state, n_state;

    logic                        r_start;
    t_coord                      r_x1, r_y1, r_x2, r_y2;
    logic signed [DIFF_BITS-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_den_abs;
    logic                        r_den_pos, r_rstrad, r_lstrad;
    logic signed [NUM_BITS-1:0]  r_num;
    t_edge_rsp                   r_rsp;

    // classification
    logic signed [THR_BITS-1:0]  qy_t, tol_t, thr_lo, thr_hi, y1_t, y2_t;
    logic                        rstrad, lstrad;
    logic signed [DIFF_BITS-1:0] qx_d, qy_d, x1_d, y1_d, x2_d, y2_d, den;

    // multiplier
    logic signed [MUL_BITS-1:0]  mul_a, mul_b, tol_m;
    logic signed [PROD_BITS-1:0] prod;

    // compare
    logic signed [CMP_BITS-1:0]  num_c, lim_c, s_add, s_sub;
    logic                        sub_pos, sub_neg, add_pos, add_neg;
    logic                        tog_r, tog_l, hit;

    pip_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        qy_t   = THR_BITS'(i_query_y);
        tol_t  = THR_BITS'(i_tolerance);
        thr_lo = qy_t - tol_t;
        thr_hi = qy_t + tol_t;
        y1_t   = THR_BITS'(r_y1);
        y2_t   = THR_BITS'(r_y2);
        rstrad = (y2_t > thr_lo) != (y1_t > thr_lo);
        lstrad = (y2_t < thr_hi) != (y1_t < thr_hi);

        qx_d = DIFF_BITS'(i_query_x);
        qy_d = DIFF_BITS'(i_query_y);
        x1_d = DIFF_BITS'(r_x1);
        y1_d = DIFF_BITS'(r_y1);
        x2_d = DIFF_BITS'(r_x2);
        y2_d = DIFF_BITS'(r_y2);
        den  = y1_d - y2_d;
    end

    // operand select for the shared multiplier
    always_comb begin
        tol_m = MUL_BITS'(i_tolerance);
        case (r_state)
            E_MUL1: begin
                mul_a = MUL_BITS'(r_dx2);
                mul_b = MUL_BITS'(r_dy1);
            end
            E_MUL2: begin
                mul_a = MUL_BITS'(r_dx1);
                mul_b = MUL_BITS'(r_dy2);
            end
            E_MUL3: begin
                mul_a = tol_m;
                mul_b = MUL_BITS'(r_den_abs);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // offset num/|den| against +/-tol, with the sign of den folded into
    // which side of the band counts as right or left
    always_comb begin
        num_c   = CMP_BITS'(r_num);
        lim_c   = CMP_BITS'(prod);
        s_add   = num_c + lim_c;
        s_sub   = num_c - lim_c;
        sub_neg = s_sub[CMP_BITS-1];
        sub_pos = !sub_neg && (s_sub != '0);
        add_neg = s_add[CMP_BITS-1];
        add_pos = !add_neg && (s_add != '0);
        tog_r   = r_rstrad && (r_den_pos ? sub_pos : add_neg);
        tog_l   = r_lstrad && (r_den_pos ? add_neg : sub_pos);
        hit     = sub_neg && add_pos;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE: if (i_req.valid) begin
                n_state = E_CLS;
            end
            E_CLS: begin
                if (r_start || (!rstrad && !lstrad)) n_state = E_IDLE;
                else n_state = E_MUL1;
            end
            E_MUL1: n_state = E_MUL2;
            E_MUL2: n_state = E_MUL3;
            E_MUL3: n_state = E_CMP;
            E_CMP:  n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_rsp   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                E_CLS: begin
                    if (r_start || (!rstrad && !lstrad)) begin
                        r_rsp <= '{done: 1'b1, tog_right: 1'b0, tog_left: 1'b0, hit: 1'b0};
                    end else begin
                        r_rsp.done <= 1'b0;
                    end
                end
                E_CMP: begin
                    r_rsp <= '{done: 1'b1, tog_right: tog_r, tog_left: tog_l, hit: hit};
                end
                default: r_rsp.done <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == E_IDLE && i_req.valid) begin
            r_start <= i_req.ring_start;
            r_x1    <= i_req.x1;
            r_y1    <= i_req.y1;
            r_x2    <= i_req.x2;
            r_y2    <= i_req.y2;
        end
        if (r_state == E_CLS) begin
            r_dx1     <= x1_d - qx_d;
            r_dy1     <= y1_d - qy_d;
            r_dx2     <= x2_d - qx_d;
            r_dy2     <= y2_d - qy_d;
            r_den_pos <= !den[DIFF_BITS-1];
            r_den_abs <= den[DIFF_BITS-1] ? -den : den;
            r_rstrad  <= rstrad;
            r_lstrad  <= lstrad;
        end
        if (r_state == E_MUL2) r_num <= NUM_BITS'(prod);
        if (r_state == E_MUL3) r_num <= r_num - NUM_BITS'(prod);
    end

    assign o_rsp = r_rsp;

endmodule

### hdl/pip_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checks for the crossing test unit, attached by bind.
// ----------------------------------------------------------------------------
module pip_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_inside_res,
    input logic o_on_boundary
);

    // a stalled result request stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a point on the boundary always counts as inside
    a_bnd_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_on_boundary |-> o_inside_res)
        else $error("on_boundary without inside_res");

    // an accepted vertex raises the input stall, so vertices are never taken back to back
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("vertex accepted on back-to-back cycles");

    // a result request does not rise straight after an accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared the cycle after an accept");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request not cleared by reset");

endmodule

bind point_in_polygon_crossing_test_unit pip_chk u_pip_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_inside_res  (o_inside_res),
    .o_on_boundary (o_on_boundary)
);
